FILE: rtl/core/prime_gap_finder_macros.svh
// Assertion macros shared by the RTL. Each one samples on clk and is off during reset.
`ifndef PRIME_GAP_FINDER_MACROS_SVH
`define PRIME_GAP_FINDER_MACROS_SVH

// The condition implies the expression in the same cycle.
`define PGF_ASSERT_SAME(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// The condition implies the expression in the next cycle.
`define PGF_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: rtl/core/pgf_pkg.sv
package pgf_pkg;

	// Width of each result field on the output stream.
	localparam int OUT_W = 16;

	// Constant added to the square in every trial. An even d adds one more.
	localparam int TRIAL_BASE = 3;

	// Smallest odd candidate that needs any trial.
	localparam int FIRST_TRIED = 5;

	// Last trial value of d. The search runs d from n-1 down to this.
	localparam int LAST_D = 3;

	// States of the bit-serial square-and-reduce unit.
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_DBL,
		SQ_ADD,
		SQ_FIN
	} sq_state_t;

	// States of the candidate sequencer.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_DONE
	} pgf_state_t;

	// Request from the sequencer to the square unit.
	typedef struct packed {
		logic start;
		logic add_one;
	} sq_req_t;

	// Response from the square unit.
	typedef struct packed {
		logic done;
		logic hit;
	} sq_rsp_t;

endpackage

FILE: rtl/core/pgf_sqmod.sv
// One trial of the rule: r = (d*d + 3 + add_one) mod 4n, hit when r/4 equals one.
// The square is built by shifting d in one bit at a time, MSB first, as a
// double step then a conditional add, each followed by one compare-subtract.
module pgf_sqmod import pgf_pkg::*; #(
	parameter int NUM_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sq_req_t             req,
	input  logic [NUM_BITS-1:0] d,
	input  logic [NUM_BITS-1:0] n,
	output sq_rsp_t             rsp
);

	localparam int AW    = NUM_BITS + 2;
	localparam int CNT_W = $clog2(NUM_BITS);

	sq_state_t           state_q, state_d;
	logic [AW-1:0]       acc_q;
	logic [AW-1:0]       mod_q;
	logic [NUM_BITS-1:0] d_q;
	logic [NUM_BITS-1:0] sh_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                add_one_q;

	logic [AW:0]         dbl;
	logic [AW-1:0]       dbl_red;
	logic [AW:0]         sum;
	logic [AW-1:0]       sum_red;
	logic [AW:0]         fin;
	logic [AW-1:0]       fin_red;
	logic [2:0]          fin_add;
	logic                last_bit;

	// Doubling step, reduced once since acc stays below the modulus.
	assign dbl     = {acc_q, 1'b0};
	assign dbl_red = (dbl >= {1'b0, mod_q}) ? AW'(dbl - {1'b0, mod_q}) : AW'(dbl);

	// Add step for the current bit of d.
	assign sum     = {1'b0, acc_q} + (AW + 1)'(sh_q[NUM_BITS-1] ? d_q : '0);
	assign sum_red = (sum >= {1'b0, mod_q}) ? AW'(sum - {1'b0, mod_q}) : AW'(sum);

	// Final offset of three or four, then the hit test on r/4.
	assign fin_add = 3'(TRIAL_BASE) + {2'b00, add_one_q};
	assign fin     = {1'b0, acc_q} + (AW + 1)'(fin_add);
	assign fin_red = (fin >= {1'b0, mod_q}) ? AW'(fin - {1'b0, mod_q}) : AW'(fin);

	assign last_bit = (cnt_q == CNT_W'(NUM_BITS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (req.start) state_d = SQ_DBL;
			SQ_DBL:  state_d = SQ_ADD;
			SQ_ADD:  state_d = last_bit ? SQ_FIN : SQ_DBL;
			SQ_FIN:  state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		rsp.done = 1'b0;
		rsp.hit  = 1'b0;
		case (state_q)
			SQ_FIN: begin
				rsp.done = 1'b1;
				rsp.hit  = (fin_red[AW-1:2] == (AW - 2)'(1));
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (req.start) begin
					acc_q     <= '0;
					mod_q     <= {n, 2'b00};
					d_q       <= d;
					sh_q      <= d;
					cnt_q     <= '0;
					add_one_q <= req.add_one;
				end
			end
			SQ_DBL: acc_q <= dbl_red;
			SQ_ADD: begin
				acc_q <= sum_red;
				sh_q  <= {sh_q[NUM_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/prime_gap_finder.sv
// Prime gap finder: tests candidates in the order given and reports prime pairs.
// Input stream: s_tdata carries the candidate, s_tuser the new-range flag, which
// forgets the remembered prime before the candidate is tested.
// Output stream: one item per candidate, carrying is_prime and gap_found in
// m_tuser and the lower prime, upper prime and gap in m_tdata.
// One candidate is worked on at a time. Zero, one, two, three and even numbers
// go straight to the done state of the sequencer and from there into the output
// register. An odd n of five or more runs up to n-3 trials through the bit-serial
// square unit, one bit of d per double and add pair, and ends early at the first hit.
// A new candidate is taken once the previous one has its result in the output
// register, even while the receiver has not yet taken that result.
// When the receiver stalls, the result waits in the output register and a
// finished candidate after it waits in the sequencer until the register frees.
// Reset clears the remembered prime and empties the output register.
module prime_gap_finder import pgf_pkg::*; #(
	parameter int NUM_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((NUM_BITS + 7) / 8) * 8-1:0] s_tdata,  // number
	input  logic                                s_tuser,  // new_range
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [3*OUT_W-1:0]                  m_tdata,  // lower_prime, upper_prime, gap
	output logic [1:0]                          m_tuser   // is_prime, gap_found
);

	`include "prime_gap_finder_macros.svh"

	pgf_state_t          state_q, state_d;
	logic [NUM_BITS-1:0] n_q;
	logic [NUM_BITS-1:0] d_q;
	logic                prime_q;
	logic [NUM_BITS-1:0] last_prime_q;
	logic                have_prime_q;
	logic                m_tvalid_q;
	logic [3*OUT_W-1:0]  m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic [NUM_BITS-1:0] num;
	logic                accept;
	logic                needs_trials;
	logic                small_prime;
	logic                load_out;
	logic                pair;
	logic [NUM_BITS-1:0] diff;
	sq_req_t             sq_req;
	sq_rsp_t             sq_rsp;

	assign num          = s_tdata[NUM_BITS-1:0];
	assign accept       = s_tvalid && s_tready;
	assign needs_trials = num[0] && (num >= NUM_BITS'(FIRST_TRIED));
	assign small_prime  = (num == NUM_BITS'(2)) || (num == NUM_BITS'(3));
	assign pair         = prime_q && have_prime_q;
	assign diff         = n_q - last_prime_q;

	// Square-and-reduce unit for one trial value of d.
	pgf_sqmod #(
		.NUM_BITS (NUM_BITS)
	) u_sqmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.d      (d_q),
		.n      (n_q),
		.rsp    (sq_rsp)
	);

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = needs_trials ? ST_START : ST_DONE;
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (sq_rsp.done) begin
					if (sq_rsp.hit || (d_q == NUM_BITS'(LAST_D))) state_d = ST_DONE;
					else state_d = ST_START;
				end
			end
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready       = 1'b0;
		sq_req.start   = 1'b0;
		sq_req.add_one = ~d_q[0];
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_START: sq_req.start = 1'b1;
			ST_DONE:  load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// Control state, remembered prime and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_prime_q <= 1'b0;
			last_prime_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && s_tuser) begin
				have_prime_q <= 1'b0;
				last_prime_q <= '0;
			end
			if (load_out && prime_q) begin
				have_prime_q <= 1'b1;
				last_prime_q <= n_q;
			end
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Candidate, trial counter and verdict.
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q     <= num;
			d_q     <= num - NUM_BITS'(1);
			prime_q <= small_prime;
		end else if (state_q == ST_WAIT && sq_rsp.done) begin
			if (sq_rsp.hit) prime_q <= 1'b0;
			else if (d_q == NUM_BITS'(LAST_D)) prime_q <= 1'b1;
			else d_q <= d_q - NUM_BITS'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser_q <= {pair, prime_q};
			m_tdata_q <= {
				pair ? OUT_W'(diff) : OUT_W'(0),
				prime_q ? OUT_W'(n_q) : OUT_W'(0),
				pair ? OUT_W'(last_prime_q) : OUT_W'(0)
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks on the sequencer and the result fields.
	`PGF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accepted item left the sequencer idle")
	`PGF_ASSERT_SAME(a_pair_is_prime, m_tvalid && m_tuser[1], m_tuser[0], "pair reported for a composite")
	`PGF_ASSERT_SAME(a_composite_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "composite result carries data")

endmodule

FILE: verif/tb_prime_gap_finder.sv
module tb_prime_gap_finder;
	timeunit 1ns;
	timeprecision 1ps;

	import pgf_pkg::*;

	localparam int NUM_BITS = 16;
	localparam int IN_W = ((NUM_BITS + 7) / 8) * 8;
	// Per-trial allowance for the square unit in the watchdog budget.
	localparam int TRIAL_CYCLES = 2 * NUM_BITS + 2;
	// Most candidates stay small so that the trial search stays short.
	localparam int SMALL_MAX = 127;
	// A large odd candidate is only used when its search ends this early.
	localparam int BIG_ODD_TRIALS = 40;
	localparam int HOLD_OFF_LEN = 600;
	localparam int DRAIN_CYCLES = 50;

	typedef struct {
		logic [NUM_BITS-1:0] number;
		logic                new_range;
	} candidate_t;

	typedef struct packed {
		logic             is_prime;
		logic             gap_found;
		logic [OUT_W-1:0] lower_prime;
		logic [OUT_W-1:0] upper_prime;
		logic [OUT_W-1:0] gap;
	} gap_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;  // number
	logic                 s_tuser = 1'b0;  // new_range
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [3*OUT_W-1:0]   m_tdata;  // lower_prime, upper_prime, gap
	logic [1:0]           m_tuser;  // is_prime, gap_found

	// Our own copy of the remembered prime.
	logic [NUM_BITS-1:0]  tracked_prime = '0;
	bit                   tracked_valid = 1'b0;

	candidate_t           pending_candidates[$];
	gap_report_t          expected_reports[$];
	int unsigned          error_count = 0;
	int unsigned          send_idle_pct = 0;
	int unsigned          recv_stall_pct = 0;
	int unsigned          hold_off_requests = 0;
	int unsigned          hold_off_served = 0;
	int unsigned          hold_off_left = 0;
	longint unsigned      cycle_count = 0;
	longint unsigned      cycle_budget = 0;

	prime_gap_finder #(
		.NUM_BITS(NUM_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #4 clk = ~clk;

	// Primality rule of the block; also returns how many trials were run.
	function automatic bit rule_verdict(input longint unsigned n, output int unsigned trials);
		longint unsigned d;
		longint unsigned v;
		trials = 0;
		if (n < 2) begin
			return 1'b0;
		end
		if ((n & 1) == 0) begin
			return n == 2;
		end
		for (longint unsigned j = 1; j < n - 2; j++) begin
			trials++;
			d = n - j;
			v = (d * d + 3 + (j & 1)) / 4;
			if (v % n == 1) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Work out the report for one accepted candidate and update the remembered prime.
	function automatic gap_report_t next_gap_report(input logic [NUM_BITS-1:0] n,
			input logic restart);
		gap_report_t rep;
		int unsigned trials;
		rep = '0;
		if (restart) begin
			tracked_valid = 1'b0;
			tracked_prime = '0;
		end
		if (rule_verdict(64'(n), trials)) begin
			rep.is_prime = 1'b1;
			rep.upper_prime = n;
			if (tracked_valid) begin
				rep.gap_found = 1'b1;
				rep.lower_prime = tracked_prime;
				rep.gap = n - tracked_prime;
			end
			tracked_prime = n;
			tracked_valid = 1'b1;
		end
		return rep;
	endfunction

	// A large odd number whose search hits early, or a large even one if none turns up.
	function automatic logic [NUM_BITS-1:0] cheap_big_odd();
		logic [NUM_BITS-1:0] c;
		int unsigned trials;
		for (int k = 0; k < 64; k++) begin
			c = NUM_BITS'($urandom_range(32768, 65535) | 1);
			if (!rule_verdict(64'(c), trials) && trials <= BIG_ODD_TRIALS) begin
				return c;
			end
		end
		return NUM_BITS'($urandom_range(32768, 65535) & 32'hFFFE);
	endfunction

	// Queue one candidate and extend the cycle allowance by the length of its search.
	task automatic queue_candidate(input logic [NUM_BITS-1:0] n, input logic restart);
		candidate_t item;
		int unsigned trials;
		void'(rule_verdict(64'(n), trials));
		cycle_budget += (trials + 1) * TRIAL_CYCLES + 8;
		item.number = n;
		item.new_range = restart;
		pending_candidates.push_back(item);
	endtask

	task automatic wait_drained();
		while (pending_candidates.size() != 0 || s_tvalid || expected_reports.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// One non-descending run of small candidates that opens a new range.
	task automatic queue_range_run();
		int unsigned n;
		int unsigned len;
		n = $urandom_range(0, 60);
		len = $urandom_range(3, 10);
		queue_candidate(NUM_BITS'(n), 1'b1);
		for (int k = 1; k < len; k++) begin
			n += ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 4);
			if (n > SMALL_MAX) begin
				break;
			end
			queue_candidate(NUM_BITS'(n), 1'b0);
		end
	endtask

	// A stray candidate: random even, large odd with an early hit, or small out of order.
	task automatic queue_noise();
		logic [NUM_BITS-1:0] n;
		case ($urandom_range(2))
			0: n = NUM_BITS'($urandom & 32'hFFFE);
			1: n = cheap_big_odd();
			default: n = NUM_BITS'($urandom_range(0, SMALL_MAX));
		endcase
		queue_candidate(n, 1'($urandom_range(1)));
	endtask

	// Sender: offers the next pending item whenever the slot is free, unless it idles at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin : drive
			candidate_t next_item;
			if (s_tvalid && s_tready) begin
				expected_reports.push_back(next_gap_report(s_tdata[NUM_BITS-1:0], s_tuser));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_candidates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_candidates.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.number;
					s_tuser <= next_item.new_range;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off_left <= 0;
			hold_off_served <= 0;
		end else if (hold_off_served != hold_off_requests) begin
			hold_off_served <= hold_off_requests;
			hold_off_left <= HOLD_OFF_LEN;
			m_tready <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Check each accepted result against the oldest expected report.
	always @(posedge clk) begin : check
		gap_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
					$time, m_tuser, m_tdata);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				check_field("is_prime", want.is_prime, m_tuser[0]);
				check_field("gap_found", want.gap_found, m_tuser[1]);
				check_field("lower_prime", want.lower_prime, m_tdata[OUT_W-1:0]);
				check_field("upper_prime", want.upper_prime, m_tdata[2*OUT_W-1:OUT_W]);
				check_field("gap", want.gap, m_tdata[3*OUT_W-1:2*OUT_W]);
			end
		end
	end

	// Watchdog against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * cycle_budget + 100000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned trials;
		int unsigned top_prime;
		int unsigned queued;
		int unsigned idle_modes[4][2];
		idle_modes = '{'{0, 0}, '{59, 0}, '{0, 59}, '{15, 15}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Largest affordable prime by the block's rule.
		top_prime = 1099;
		while (!rule_verdict(64'(top_prime), trials)) begin
			top_prime -= 2;
		end

		// Directed part, no idling: small numbers, repeats, descending and wrapping gaps.
		queue_candidate(0, 1'b1);
		queue_candidate(1, 1'b0);
		queue_candidate(2, 1'b0);
		queue_candidate(3, 1'b0);
		queue_candidate(3, 1'b0);
		queue_candidate(4, 1'b0);
		queue_candidate(5, 1'b0);
		queue_candidate(9, 1'b0);
		queue_candidate(7, 1'b0);
		queue_candidate(2, 1'b1);
		queue_candidate(65534, 1'b0);
		if (!rule_verdict(65535, trials) && trials <= BIG_ODD_TRIALS) begin
			queue_candidate(65535, 1'b0);
		end
		queue_candidate(cheap_big_odd(), 1'b0);
		queue_candidate(13, 1'b0);
		queue_candidate(11, 1'b0);
		queue_candidate(NUM_BITS'(top_prime), 1'b1);
		queue_candidate(1, 1'b0);
		queue_candidate(17, 1'b0);
		queue_candidate(8, 1'b1);
		queue_candidate(5, 1'b0);
		queue_candidate(7, 1'b0);
		wait_drained();

		// Receiver holds off while fast items keep coming, so the input backs up.
		cycle_budget += HOLD_OFF_LEN;
		hold_off_requests++;
		for (int k = 0; k < 8; k++) begin
			queue_candidate(NUM_BITS'($urandom & 32'hFFFE), 1'($urandom_range(1)));
		end
		wait_drained();

		// Random part: mostly ascending runs, some noise, under each idling mode.
		foreach (idle_modes[m]) begin
			send_idle_pct = idle_modes[m][0];
			recv_stall_pct = idle_modes[m][1];
			queued = 0;
			while (queued < 16) begin
				trials = pending_candidates.size();
				if ($urandom_range(99) < 80) begin
					queue_range_run();
				end else begin
					queue_noise();
				end
				queued += pending_candidates.size() - trials;
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
